FILE: rtl/bbpa_pkg.sv
// shared types and constants for the block pool allocator
package bbpa_pkg;
   localparam int MAX_PAGES  = 16;
   localparam int MAX_BLOCKS = 256;
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int BLK_W      = $clog2(MAX_BLOCKS);
   localparam int OPEN_W     = PAGE_W + 1;
   localparam int CNT_W      = BLK_W + 1;
   localparam int SEG_W      = 16;
   localparam int NSEG       = MAX_BLOCKS / SEG_W;
   localparam int SEG_IW     = $clog2(NSEG);

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_FULL         = 2'd1;
   localparam logic [1:0] ST_NO_PAGE      = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   localparam logic [1:0] CSR_BLOCK_BYTES = 2'd0;
   localparam logic [1:0] CSR_PAGE_BYTES  = 2'd1;
   localparam logic [1:0] CSR_BLOCKS      = 2'd2;
   localparam logic [1:0] CSR_BASE        = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request, reset page index to newest
      logic rd_page;     // read map row and count of page index
      logic seg_init;    // begin segment scan of the read row
      logic seg_step;    // examine next segment
      logic page_dec;    // move to older page
      logic open_page;   // open a new page, write row and count
      logic take_block;  // clear found bit, bump count
      logic off_calc;    // compute offset for current page
      logic div_init;    // start offset division
      logic div_step;    // one quotient bit
      logic give_block;  // set bit, drop count
      logic mul_init;    // start address multiply
      logic mul_step;    // one multiplier bit
      logic respond;     // drive result
      logic [1:0] rsp_status;
   } bbpa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;
      logic page_left;   // page index still points at an open page
      logic pool_full;
      logic seg_found;
      logic seg_done;
      logic in_page;
      logic div_done;
      logic blk_bad;     // block index out of map or already free
      logic mul_done;
   } bbpa_sts_type;
endpackage

FILE: rtl/bitmap_block_pool_allocator_unit.sv
// top level of the bitmap block pool allocator
// one item at a time, busy while working
// alloc: takes the lowest free block of the newest page with one, in 16-block segments, passing
// over full pages; opens a page when all are full; pool full when no page is left to open
// free: pages tried newest first, 32-step divider in the holding page; no page if none holds it
// result strobe lasts one cycle and cannot be stalled; next start taken in that cycle
// synchronous reset closes all pages and loads register defaults; no clearing pass.
module bitmap_block_pool_allocator_unit
   import bbpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_block_address,
   output logic [3:0]  rsp_page_number,
   output logic [8:0]  rsp_page_use_count
);
   bbpa_cmd_type cmd;
   bbpa_sts_type sts;

   assign csr_ready = 1'b1;

   bbpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   bbpa_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_op(req_op), .req_address(req_address),
      .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address), .rsp_page_number(rsp_page_number),
      .rsp_page_use_count(rsp_page_use_count)
   );
endmodule

FILE: rtl/bbpa_datapath.sv
// datapath: page maps, counts, scan, divider and multiplier
module bbpa_datapath
   import bbpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 req_op,
   input  logic [31:0]          req_address,
   input  bbpa_cmd_type         cmd,
   output bbpa_sts_type         sts,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_block_address,
   output logic [3:0]           rsp_page_number,
   output logic [8:0]           rsp_page_use_count
);
   logic [12:0] block_bytes_ff;
   logic [16:0] page_bytes_ff;
   logic [8:0]  blocks_ff;
   logic [31:0] base_ff;
   logic [OPEN_W-1:0] open_ff;

   logic [MAX_BLOCKS-1:0] map_mem [MAX_PAGES];
   logic [CNT_W-1:0]      cnt_mem [MAX_PAGES];

   logic op_ff;
   logic [31:0] addr_ff;
   logic [OPEN_W-1:0] pidx_ff;   // pages left to look at; current page is pidx_ff-1
   logic [MAX_BLOCKS-1:0] row_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SEG_IW:0] seg_ff;
   logic seg_found_ff;
   logic [BLK_W-1:0] blk_ff;
   logic [31:0] pstart_ff;       // start of current page
   logic [31:0] off_ff;
   logic in_page_ff;
   logic [31:0] quo_ff;
   logic [13:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic [31:0] prod_ff;
   logic [31:0] mcand_ff;
   logic [CNT_W-1:0] mplier_ff;
   logic [4:0] mcnt_ff;
   logic rsp_ff;
   logic [1:0] rst_ff;
   logic [31:0] raddr_ff;
   logic [3:0] rpage_ff;
   logic [8:0] rcnt_ff;

   logic [12:0] eff_bb;
   logic [CNT_W-1:0] eff_nb;
   logic [PAGE_W-1:0] cur_page;
   logic [PAGE_W-1:0] new_page;
   logic [SEG_IW-1:0] seg_i;
   logic [SEG_W-1:0] seg_bits;
   logic [SEG_W-1:0] seg_mask;
   logic [$clog2(SEG_W)-1:0] seg_pos;
   logic seg_hit;
   logic [13:0] rem_sh;
   logic [BLK_W-1:0] div_blk;
   logic div_bad;

   assign eff_bb   = (block_bytes_ff == 13'd0) ? 13'd1 : block_bytes_ff;
   assign eff_nb   = (blocks_ff == 9'd0) ? CNT_W'(1) :
                     (blocks_ff > 9'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_ff);
   assign cur_page = PAGE_W'(pidx_ff - OPEN_W'(1));
   assign new_page = open_ff[PAGE_W-1:0];
   assign seg_i    = seg_ff[SEG_IW-1:0];
   assign seg_bits = row_ff[seg_i*SEG_W +: SEG_W];

   always_comb begin
      seg_mask = '0;
      for (int i = 0; i < SEG_W; i++) begin
         seg_mask[i] = (CNT_W'(seg_i) * CNT_W'(SEG_W) + CNT_W'(i)) < eff_nb;
      end
   end

   always_comb begin
      seg_pos = '0;
      seg_hit = 1'b0;
      for (int i = SEG_W - 1; i >= 0; i--) begin
         if (seg_bits[i] && seg_mask[i]) begin
            seg_pos = i[$clog2(SEG_W)-1:0];
            seg_hit = 1'b1;
         end
      end
   end

   assign rem_sh  = {rem_ff[12:0], off_ff[31]};
   assign div_bad = quo_ff >= 32'(MAX_BLOCKS);
   assign div_blk = quo_ff[BLK_W-1:0];

   assign sts.is_free   = op_ff;
   assign sts.page_left = pidx_ff != '0;
   assign sts.pool_full = open_ff >= OPEN_W'(MAX_PAGES);
   assign sts.seg_found = seg_found_ff;
   assign sts.seg_done  = seg_ff == (SEG_IW+1)'(NSEG);
   assign sts.in_page   = in_page_ff;
   assign sts.div_done  = dcnt_ff == 6'd32;
   assign sts.blk_bad   = div_bad || row_ff[div_blk];
   assign sts.mul_done  = mcnt_ff == 5'(CNT_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= 13'd64;
         page_bytes_ff  <= 17'd4096;
         blocks_ff      <= 9'd64;
         base_ff        <= '0;
         open_ff        <= '0;
         rsp_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BLOCK_BYTES: block_bytes_ff <= csr_data[12:0];
               CSR_PAGE_BYTES:  page_bytes_ff  <= csr_data[16:0];
               CSR_BLOCKS:      blocks_ff      <= csr_data[8:0];
               CSR_BASE:        base_ff        <= csr_data;
            endcase
         end
         if (cmd.open_page) open_ff <= open_ff + OPEN_W'(1);
         rsp_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
         pidx_ff <= open_ff;
      end
      if (cmd.page_dec) pidx_ff <= pidx_ff - OPEN_W'(1);
      if (cmd.rd_page) begin
         row_ff <= map_mem[cur_page];
         cnt_ff <= cnt_mem[cur_page];
      end
      if (cmd.seg_init) begin
         seg_ff       <= '0;
         seg_found_ff <= 1'b0;
      end
      if (cmd.seg_step) begin
         if (seg_hit) begin
            seg_found_ff <= 1'b1;
            blk_ff <= BLK_W'(seg_i * SEG_W) + BLK_W'(seg_pos);
         end else begin
            seg_ff <= seg_ff + (SEG_IW+1)'(1);
         end
      end
      if (cmd.take_block) begin
         map_mem[cur_page][blk_ff] <= 1'b0;
         cnt_mem[cur_page] <= cnt_ff + CNT_W'(1);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.open_page) begin
         map_mem[new_page] <= {{(MAX_BLOCKS-1){1'b1}}, 1'b0};
         cnt_mem[new_page] <= CNT_W'(1);
         cnt_ff <= CNT_W'(1);
         pidx_ff <= open_ff + OPEN_W'(1);
         blk_ff <= '0;
      end
      // offset of the request within the current page
      if (cmd.off_calc) begin
         off_ff     <= addr_ff - pstart_ff;
         in_page_ff <= (addr_ff - pstart_ff) < 32'(page_bytes_ff);
      end
      if (cmd.div_init) begin
         quo_ff  <= '0;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         off_ff  <= {off_ff[30:0], 1'b0};
         dcnt_ff <= dcnt_ff + 6'd1;
         if (rem_sh >= {1'b0, eff_bb}) begin
            rem_ff <= rem_sh - {1'b0, eff_bb};
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.give_block) begin
         map_mem[cur_page][div_blk] <= 1'b1;
         if (cnt_ff != '0) begin
            cnt_mem[cur_page] <= cnt_ff - CNT_W'(1);
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
      if (cmd.mul_init) begin
         prod_ff   <= '0;
         mcand_ff  <= 32'(page_bytes_ff);
         mplier_ff <= CNT_W'(cur_page);
         mcnt_ff   <= '0;
      end
      if (cmd.mul_step) begin
         if (mcnt_ff == 5'(CNT_W - 1)) begin
            // top multiplier bit is always zero, so the product is already complete
            pstart_ff <= base_ff + prod_ff;
         end
         if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
         mcand_ff  <= {mcand_ff[30:0], 1'b0};
         mplier_ff <= mplier_ff >> 1;
         mcnt_ff   <= mcnt_ff + 5'd1;
      end
      if (cmd.respond) begin
         rst_ff <= cmd.rsp_status;
         if (cmd.rsp_status == ST_OK) begin
            raddr_ff <= op_ff ? 32'd0 : pstart_ff + 32'(blk_ff) * 32'(eff_bb);
            rpage_ff <= 4'(cur_page);
            rcnt_ff  <= 9'(cnt_ff);
         end else begin
            raddr_ff <= '0;
            rpage_ff <= '0;
            rcnt_ff  <= '0;
         end
      end
   end

   assign rsp_strobe         = rsp_ff;
   assign rsp_status         = rst_ff;
   assign rsp_block_address  = raddr_ff;
   assign rsp_page_number    = rpage_ff;
   assign rsp_page_use_count = rcnt_ff;
endmodule

FILE: rtl/bbpa_ctrl.sv
// controller state machine for the block pool allocator
module bbpa_ctrl
   import bbpa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  bbpa_sts_type sts,
   output bbpa_cmd_type cmd
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_OPEN  = 4'd4;
   localparam logic [3:0] S_PMUL  = 4'd5;
   localparam logic [3:0] S_OFF   = 4'd6;
   localparam logic [3:0] S_CHK   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_GIVE  = 4'd9;
   localparam logic [3:0] S_RSP   = 4'd10;
   localparam logic [3:0] S_WAIT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] st_ff, st_in;

   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      st_in = st_ff;
      cmd.rsp_status = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            priority if (!sts.page_left) begin
               if (sts.is_free) begin
                  st_in = ST_NO_PAGE;
                  state_in = S_RSP;
               end else if (sts.pool_full) begin
                  st_in = ST_FULL;
                  state_in = S_RSP;
               end else begin
                  state_in = S_OPEN;
               end
            end else begin
               cmd.rd_page = 1'b1;
               cmd.mul_init = 1'b1;
               state_in = S_READ;
            end
         end
         S_OPEN: begin
            cmd.open_page = 1'b1;
            st_in = ST_OK;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.mul_init = 1'b1;
            state_in = S_PMUL;
         end
         S_READ: begin
            cmd.seg_init = 1'b1;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            if (sts.mul_done) begin
               // status is already ok only when a page has just been opened
               priority if (sts.is_free) begin
                  state_in = S_OFF;
               end else if (st_ff == ST_OK) begin
                  state_in = S_RSP;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_SCAN: begin
            priority if (sts.seg_found) begin
               cmd.take_block = 1'b1;
               st_in = ST_OK;
               state_in = S_RSP;
            end else if (sts.seg_done) begin
               cmd.page_dec = 1'b1;
               state_in = S_DISP;
            end else begin
               cmd.seg_step = 1'b1;
            end
         end
         S_OFF: begin
            cmd.off_calc = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.in_page) begin
               cmd.div_init = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.page_dec = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_GIVE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_GIVE: begin
            if (sts.blk_bad) begin
               st_in = ST_ALREADY_FREE;
            end else begin
               cmd.give_block = 1'b1;
               st_in = ST_OK;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= (state_ff == S_IDLE) ? ST_FULL : st_in;
      end
   end
endmodule

FILE: bench/bitmap_block_pool_allocator_unit_test.sv
// self-checking testbench for the bitmap block pool allocator unit
`timescale 1ns / 100ps

module bitmap_block_pool_allocator_unit_test;
   import bbpa_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] block_address;
      logic [3:0]  page_number;
      logic [8:0]  page_use_count;
   } alloc_result_type;

   class alloc_scoreboard;
      bit [12:0]        blk_bytes = 13'd64;
      bit [16:0]        pg_bytes  = 17'd4096;
      bit [8:0]         blk_count = 9'd64;
      bit [31:0]        base      = 32'd0;
      int unsigned      pages_open;
      bit [255:0]       free_bits [MAX_PAGES];
      bit [8:0]         in_use [MAX_PAGES];
      alloc_result_type pending [$];
      bit [31:0]        live [$];
      int               errors;
      int               n_items, n_results, n_full, n_no_page, n_double, n_freed;

      function void set_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_BLOCK_BYTES: blk_bytes = data[12:0];
            CSR_PAGE_BYTES:  pg_bytes  = data[16:0];
            CSR_BLOCKS:      blk_count = data[8:0];
            default:         base      = data;
         endcase
      endfunction

      function bit [31:0] page_base(int p);
         bit [31:0] pn;
         pn = p;
         return base + pn * 32'(pg_bytes);
      endfunction

      function void push(logic [1:0] st, logic [31:0] a, int p, logic [8:0] c);
         alloc_result_type r;
         r.status = st;
         r.block_address = a;
         r.page_number = p[3:0];
         r.page_use_count = c;
         pending.push_back(r);
         case (st)
            ST_FULL:         n_full++;
            ST_NO_PAGE:      n_no_page++;
            ST_ALREADY_FREE: n_double++;
            default:         ;
         endcase
      endfunction

      function void note_request(bit op, bit [31:0] addr);
         bit [31:0] ebb, off, b, a;
         int        nb, p;
         n_items++;
         ebb = (blk_bytes == 0) ? 32'd1 : 32'(blk_bytes);
         if (op == 1'b0) begin
            nb = (blk_count == 0) ? 1 : (blk_count > MAX_BLOCKS ? MAX_BLOCKS : blk_count);
            for (p = pages_open - 1; p >= 0; p--)
               for (int k = 0; k < nb; k++)
                  if (free_bits[p][k]) begin
                     free_bits[p][k] = 1'b0;
                     in_use[p]++;
                     a = page_base(p) + 32'(k) * ebb;
                     live.push_back(a);
                     push(ST_OK, a, p, in_use[p]);
                     return;
                  end
            if (pages_open >= MAX_PAGES) begin
               push(ST_FULL, 0, 0, 0);
               return;
            end
            p = pages_open++;
            free_bits[p] = '1;
            free_bits[p][0] = 1'b0;
            in_use[p] = 1;
            live.push_back(page_base(p));
            push(ST_OK, page_base(p), p, 1);
         end else begin
            for (p = pages_open - 1; p >= 0; p--) begin
               off = addr - page_base(p);
               if (off < 32'(pg_bytes)) begin
                  b = off / ebb;
                  if (b >= MAX_BLOCKS || free_bits[p][b[7:0]]) begin
                     push(ST_ALREADY_FREE, 0, 0, 0);
                     return;
                  end
                  free_bits[p][b[7:0]] = 1'b1;
                  if (in_use[p] > 0) in_use[p]--;
                  n_freed++;
                  push(ST_OK, 0, p, in_use[p]);
                  return;
               end
            end
            push(ST_NO_PAGE, 0, 0, 0);
         end
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         n_results++;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, status %0d address %h",
                     $realtime, got.status, got.block_address);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
            errors++;
         end
         if (got.block_address !== want.block_address) begin
            $display("%0t: block_address exp %h got %h", $realtime,
                     want.block_address, got.block_address);
            errors++;
         end
         if (got.page_number !== want.page_number) begin
            $display("%0t: page_number exp %0d got %0d", $realtime,
                     want.page_number, got.page_number);
            errors++;
         end
         if (got.page_use_count !== want.page_use_count) begin
            $display("%0t: page_use_count exp %0d got %0d", $realtime,
                     want.page_use_count, got.page_use_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = 1'b0;
   logic [31:0] req_address = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_BLOCK_BYTES;
   logic [31:0] csr_data = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_block_address;
   logic [3:0]  rsp_page_number;
   logic [8:0]  rsp_page_use_count;

   alloc_scoreboard sb = new;
   int              idle_cycles;
   bit              allow_gaps;

   bitmap_block_pool_allocator_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_address(req_address),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address), .rsp_page_number(rsp_page_number),
      .rsp_page_use_count(rsp_page_use_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result check and stall watchdog
   always @(posedge clock) begin
      alloc_result_type r;
      if (!reset) begin
         if (rsp_strobe) begin
            r.status = rsp_status;
            r.block_address = rsp_block_address;
            r.page_number = rsp_page_number;
            r.page_use_count = rsp_page_use_count;
            sb.check_result(r);
         end
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // valid stays high across back-to-back register writes
   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   task automatic load_settings(logic [31:0] bb, logic [31:0] pb, logic [31:0] nb,
                                logic [31:0] rb);
      write_reg(CSR_BLOCK_BYTES, bb);
      write_reg(CSR_PAGE_BYTES, pb);
      write_reg(CSR_BLOCKS, nb);
      write_reg(CSR_BASE, rb);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one transfer in; start stays high unless a gap follows
   task automatic send(bit op, bit [31:0] addr);
      start       <= 1'b1;
      req_op      <= op;
      req_address <= addr;
      do @(posedge clock); while (busy);
      sb.note_request(op, addr);
      if (allow_gaps && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic random_item;
      int r, i;
      bit [31:0] a;
      r = $urandom_range(99);
      if (r < 50)
         send(1'b0, $urandom);
      else if (r < 82 && sb.live.size() > 0) begin
         i = $urandom_range(sb.live.size() - 1);
         a = sb.live[i];
         if ($urandom_range(9) < 7) sb.live.delete(i);
         if ($urandom_range(3) == 0) a = a + $urandom_range(0, 31);
         send(1'b1, a);
      end else if (r < 92)
         send(1'b1, sb.base + $urandom_range(0, 32'h000fffff));
      else
         send(1'b1, $urandom);
   endtask

   initial begin
      logic [31:0] bb, pb, nb, rb;
      allow_gaps = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_settings(64, 4096, 64, 0);
      // directed: reuse, double free, inside a block, outside every page
      send(1'b0, 32'hffffffff);
      send(1'b0, 0);
      send(1'b0, 0);
      send(1'b1, 32'd64);
      send(1'b1, 32'd64);
      send(1'b1, 32'd130);
      send(1'b1, 32'hffffffff);
      send(1'b0, 0);
      send(1'b1, 32'd0);
      send(1'b1, 32'h00000fff);
      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: load_settings(1, 65536, 256, 32'h1000);
               2: load_settings(0, 0, 0, 32'h80000000);
               3: load_settings(4096, 65536, 256, 32'hfffff000);
               4: load_settings(8191, 131071, 511, 32'hffffffff);
               5: load_settings(16, 256, 1, 32'h12340000);
               6: load_settings($urandom_range(1, 512), $urandom_range(1, 65536),
                                $urandom_range(1, 256), $urandom);
               default: begin
                  load_settings(32, 2048, 64, 0);
                  allow_gaps = 1'b0;
               end
            endcase
            // block index beyond the map
            if (ph == 1) send(1'b1, 32'h1000 + 300);
         end
         for (int n = 0; n < 230; n++) random_item();
      end
      drain();
      $display("ran %0d requests: %0d freed, %0d pool full, %0d outside pages, %0d already free",
               sb.n_items, sb.n_freed, sb.n_full, sb.n_no_page, sb.n_double);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

FILE: sim.f
rtl/bbpa_pkg.sv
rtl/bbpa_datapath.sv
rtl/bbpa_ctrl.sv
rtl/bitmap_block_pool_allocator_unit.sv
bench/bitmap_block_pool_allocator_unit_test.sv
